### rtl/core/grid_clearance_square_dp_unit_macros.svh
// Assertion macros for the grid clearance square block.
`ifndef GRID_CLEARANCE_SQUARE_DP_UNIT_MACROS_SVH
`define GRID_CLEARANCE_SQUARE_DP_UNIT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define GCSQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition never holds.
`define GCSQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/core/gcsq_pkg.sv
// Shared constants and types of the grid clearance square block.
package gcsq_pkg;

    localparam int MAX_WIDTH_DEF = 1024;

    localparam int COL_W  = 10;
    localparam int ROW_W  = 16;
    localparam int SIZE_W = 11;
    localparam int GW_W   = 11;
    localparam int CHAR_W = 8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_GRID_HEIGHT = 1'd1;

    localparam logic [GW_W-1:0]  GRID_WIDTH_RST  = 11'd1024;
    localparam logic [ROW_W-1:0] GRID_HEIGHT_RST = 16'd1024;

    localparam logic [SIZE_W-1:0] SIZE_SAT = {SIZE_W{1'b1}};

    localparam int FIFO_DEPTH = 2;

    // One classified item as it travels from the front to the back
    typedef struct packed {
        logic             err;
        logic             obst;
        logic             last;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_item;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic avail;
    } t_fifo_stat;

endpackage

### rtl/core/gcsq_in_if.sv
// Input channel: one raw map character per item.
interface gcsq_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] map_char;

    modport source (output valid, output map_char, input ready);
    modport sink   (input valid, input map_char, output ready);
endinterface

### rtl/core/gcsq_out_if.sv
// Output channel: one cell clearance result per item.
interface gcsq_out_if;
    logic        valid;
    logic        ready;
    logic [10:0] square_size;
    logic [9:0]  cell_col;
    logic [15:0] cell_row;
    logic        last_cell;
    logic        too_many_chars;

    modport source (output valid, output square_size, output cell_col, output cell_row,
                    output last_cell, output too_many_chars, input ready);
    modport sink   (input valid, input square_size, input cell_col, input cell_row,
                    input last_cell, input too_many_chars, output ready);
endinterface

### rtl/core/grid_clearance_square_dp_unit.sv
// Top level of the grid clearance square block: front, queue and back.
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+------------------------------------------
//   i_in     | in  | valid / ready     | map_char
//   o_out    | out | valid / ready     | square_size, cell_col, cell_row,
//            |     |                   | last_cell, too_many_chars
//   i_cfg_*  | in  | write enable only | idx 0 grid_width, idx 1 grid_height
//
// One character per cycle is taken while the queue has room; a cell result passes
// through a queue slot, the line buffer read and the output register.
// The line buffer has one write and one read port; a same-column write in the
// read cycle is bypassed, so a single-column grid also runs at full rate.
// Reset is synchronous and active low; the line buffer is not cleared.
// Input ready drops only when the two-entry queue is full, which happens only
// while the output side stalls.
module grid_clearance_square_dp_unit #(
    parameter int MAX_WIDTH = gcsq_pkg::MAX_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gcsq_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gcsq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    gcsq_in_if.sink                         i_in,
    gcsq_out_if.source                      o_out
);
    `include "grid_clearance_square_dp_unit_macros.svh"

    logic                 push;
    logic                 pop;
    gcsq_pkg::t_item      push_item;
    gcsq_pkg::t_item      head_item;
    gcsq_pkg::t_fifo_stat fifo_stat;
    logic                 err_out;
    logic                 err_zero;
    logic                 edge_out;
    logic                 edge_small;

    // Classify characters and track the raster position
    gcsq_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_fifo_stat (fifo_stat),
        .o_push      (push),
        .o_item      (push_item)
    );

    // Decouple the two sides
    gcsq_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_head  (head_item),
        .o_stat  (fifo_stat)
    );

    // Compute clearances against the line buffer
    gcsq_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fifo_stat (fifo_stat),
        .i_head      (head_item),
        .o_pop       (pop),
        .o_out       (o_out)
    );

    // Conditions watched by the checks below
    assign err_out    = o_out.valid && o_out.too_many_chars;
    assign err_zero   = (o_out.square_size == '0) && (o_out.cell_col == '0) &&
                        (o_out.cell_row == '0) && !o_out.last_cell;
    assign edge_out   = o_out.valid && ((o_out.cell_row == '0) || (o_out.cell_col == '0));
    assign edge_small = (o_out.square_size <= 11'd1);

    // Queue never takes an item while full, never gives one while empty
    `GCSQ_ASSERT_NEVER(a_fifo_overflow, i_clk, i_rst_n, push && fifo_stat.full, "queue overflow")
    `GCSQ_ASSERT_NEVER(a_fifo_underflow, i_clk, i_rst_n, pop && !fifo_stat.avail, "queue underflow")

    // An error result carries nothing but its flag
    `GCSQ_ASSERT_IMPLY(a_err_clean, i_clk, i_rst_n, err_out, err_zero, "error result not clean")

    // Cells on the top row or left column have clearance at most one
    `GCSQ_ASSERT_IMPLY(a_edge_size, i_clk, i_rst_n, edge_out, edge_small, "edge clearance above one")

endmodule

### rtl/core/gcsq_fifo.sv
// Short queue of classified items between the front and the back.
module gcsq_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  gcsq_pkg::t_item     i_item,
    input  logic                i_pop,
    output gcsq_pkg::t_item     o_head,
    output gcsq_pkg::t_fifo_stat o_stat
);
    localparam int PW = (gcsq_pkg::FIFO_DEPTH > 1) ? $clog2(gcsq_pkg::FIFO_DEPTH) : 1;
    localparam int CW = $clog2(gcsq_pkg::FIFO_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(gcsq_pkg::FIFO_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(gcsq_pkg::FIFO_DEPTH);

    gcsq_pkg::t_item r_mem [gcsq_pkg::FIFO_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == DEPTH_C);
    assign o_stat.avail = (r_count != '0);

    // Store the pushed item
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Advance pointers and track the fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/core/gcsq_front.sv
// Front part: configuration, character classification and raster position tracking.
module gcsq_front #(
    parameter int MAX_WIDTH = gcsq_pkg::MAX_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gcsq_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [gcsq_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    gcsq_in_if.sink                             i_in,
    input  gcsq_pkg::t_fifo_stat                i_fifo_stat,
    output logic                                o_push,
    output gcsq_pkg::t_item                     o_item
);
    // Compare width that covers both the width register and the largest row
    localparam int WB  = $clog2(MAX_WIDTH + 1);
    localparam int WCW = (WB > gcsq_pkg::GW_W) ? WB : gcsq_pkg::GW_W;
    localparam logic [WCW-1:0] W_CAP = WCW'(MAX_WIDTH);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_O     = 8'h4F;

    logic [gcsq_pkg::GW_W-1:0]  r_grid_width;
    logic [gcsq_pkg::ROW_W-1:0] r_grid_height;
    logic [gcsq_pkg::COL_W-1:0] r_col;
    logic [gcsq_pkg::ROW_W-1:0] r_row;
    logic                       r_full;

    logic                       acc;
    logic                       is_ws;
    logic                       is_obst;
    logic [WCW-1:0]             gw_ext;
    logic [WCW-1:0]             eff_w;
    logic [WCW-1:0]             col_p1;
    logic [gcsq_pkg::ROW_W-1:0] eff_h;
    logic [gcsq_pkg::ROW_W-1:0] n_row;
    logic                       full_now;
    logic                       wrap;
    logic                       done;

    // Accept whenever the queue has room
    assign i_in.ready = !i_fifo_stat.full;
    assign acc        = i_in.valid && i_in.ready;

    // Classify the character
    assign is_ws   = (i_in.map_char == CH_SPACE) || (i_in.map_char == CH_TAB) ||
                     (i_in.map_char == CH_LF) || (i_in.map_char == CH_CR);
    assign is_obst = (i_in.map_char == CH_S) || (i_in.map_char == CH_W) ||
                     (i_in.map_char == CH_T) || (i_in.map_char == CH_AT) ||
                     (i_in.map_char == CH_O);

    // Clamp the grid size to legal values
    assign gw_ext = WCW'(r_grid_width);
    always_comb begin
        if (r_grid_width == '0) begin
            eff_w = WCW'(1);
        end else if (gw_ext > W_CAP) begin
            eff_w = W_CAP;
        end else begin
            eff_w = gw_ext;
        end
    end
    assign eff_h = (r_grid_height == '0) ? gcsq_pkg::ROW_W'(1) : r_grid_height;

    // Work out where this cell sits and whether it ends the grid
    assign full_now = r_full || (r_row >= eff_h);
    assign col_p1   = WCW'(r_col) + WCW'(1);
    assign wrap     = (col_p1 >= eff_w);
    assign n_row    = r_row + gcsq_pkg::ROW_W'(1);
    assign done     = wrap && ((n_row >= eff_h) || (n_row == '0));

    // Hand the classified item to the queue
    assign o_push      = acc && !is_ws;
    assign o_item.err  = full_now;
    assign o_item.obst = is_obst;
    assign o_item.last = !full_now && done;
    assign o_item.col  = full_now ? '0 : r_col;
    assign o_item.row  = full_now ? '0 : r_row;

    // Hold configuration and advance the raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= gcsq_pkg::GRID_WIDTH_RST;
            r_grid_height <= gcsq_pkg::GRID_HEIGHT_RST;
            r_col         <= '0;
            r_row         <= '0;
            r_full        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    gcsq_pkg::CFG_IDX_GRID_WIDTH: begin
                        r_grid_width <= i_cfg_data[gcsq_pkg::GW_W-1:0];
                    end
                    gcsq_pkg::CFG_IDX_GRID_HEIGHT: begin
                        r_grid_height <= i_cfg_data[gcsq_pkg::ROW_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (o_push) begin
                if (full_now) begin
                    r_full <= 1'b1;
                end else if (wrap) begin
                    r_col <= '0;
                    r_row <= n_row;
                    if (done) begin
                        r_full <= 1'b1;
                    end
                end else begin
                    r_col <= col_p1[gcsq_pkg::COL_W-1:0];
                end
            end
        end
    end

endmodule

### rtl/core/gcsq_back.sv
// Back part: line buffer, clearance recurrence and output register.
module gcsq_back #(
    parameter int MAX_WIDTH = gcsq_pkg::MAX_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gcsq_pkg::t_fifo_stat i_fifo_stat,
    input  gcsq_pkg::t_item      i_head,
    output logic                 o_pop,
    gcsq_out_if.source           o_out
);
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int SW = gcsq_pkg::SIZE_W;

    // Line buffer with the clearances of the upper row
    logic [SW-1:0]   r_line [MAX_WIDTH];
    logic [SW-1:0]   r_rd_data;
    logic            r_fwd;
    logic [SW-1:0]   r_fwd_data;

    // Compute stage
    logic            r_c_vld;
    gcsq_pkg::t_item r_c_item;
    logic [SW-1:0]   r_left;
    logic [SW-1:0]   r_diag;

    // Output register
    logic                       r_o_vld;
    logic [SW-1:0]              r_o_size;
    logic [gcsq_pkg::COL_W-1:0] r_o_col;
    logic [gcsq_pkg::ROW_W-1:0] r_o_row;
    logic                       r_o_last;
    logic                       r_o_err;

    logic            c_adv;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;
    logic            wr_en;
    logic [SW-1:0]   up_raw;
    logic [SW-1:0]   up;
    logic [SW-1:0]   left;
    logic [SW-1:0]   diag;
    logic [SW-1:0]   m1;
    logic [SW-1:0]   mn;
    logic [SW-1:0]   v;

    // Move forward when the output register is free or being drained
    assign c_adv = r_c_vld && (!r_o_vld || o_out.ready);
    assign o_pop = i_fifo_stat.avail && (!r_c_vld || c_adv);

    assign rd_addr = AW'(i_head.col);
    assign wr_addr = AW'(r_c_item.col);
    assign wr_en   = c_adv && !r_c_item.err;

    // Pick neighbor values, zero outside the grid
    assign up_raw = r_fwd ? r_fwd_data : r_rd_data;
    assign up     = (r_c_item.row != '0) ? up_raw : '0;
    assign left   = (r_c_item.col != '0) ? r_left : '0;
    assign diag   = (r_c_item.col != '0) ? r_diag : '0;

    // One plus the minimum of the three, saturated; zero for an obstacle
    assign m1 = (up < left) ? up : left;
    assign mn = (m1 < diag) ? m1 : diag;
    always_comb begin
        if (r_c_item.obst) begin
            v = '0;
        end else if (mn == gcsq_pkg::SIZE_SAT) begin
            v = gcsq_pkg::SIZE_SAT;
        end else begin
            v = mn + SW'(1);
        end
    end

    // Write the new clearance and read the upper-row entry of the next item
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_line[wr_addr] <= v;
        end
        if (o_pop) begin
            r_rd_data <= r_line[rd_addr];
        end
    end

    // Bypass a write to the same column that lands in the read cycle
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_fwd      <= wr_en && (wr_addr == rd_addr);
            r_fwd_data <= v;
        end
    end

    // Hold the item in the compute stage and the left and diagonal values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
            r_left  <= '0;
            r_diag  <= '0;
        end else begin
            if (o_pop) begin
                r_c_vld <= 1'b1;
            end else if (c_adv) begin
                r_c_vld <= 1'b0;
            end
            if (wr_en) begin
                r_left <= v;
                r_diag <= up;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_c_item <= i_head;
        end
    end

    // Load the result and drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (c_adv) begin
            r_o_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_adv) begin
            r_o_size <= r_c_item.err ? '0 : v;
            r_o_col  <= r_c_item.col;
            r_o_row  <= r_c_item.row;
            r_o_last <= r_c_item.last;
            r_o_err  <= r_c_item.err;
        end
    end

    assign o_out.valid          = r_o_vld;
    assign o_out.square_size    = r_o_size;
    assign o_out.cell_col       = r_o_col;
    assign o_out.cell_row       = r_o_row;
    assign o_out.last_cell      = r_o_last;
    assign o_out.too_many_chars = r_o_err;

endmodule

### verif/gcsq_clearance_checker.sv
// Checker for the grid clearance square block: predicts every cell result and compares it.
module gcsq_clearance_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gcsq_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gcsq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    gcsq_in_if                              map_ch,
    gcsq_out_if                             cell_ch,
    output int                              o_pending,
    output int                              o_cells,
    output int                              o_errors
);

    localparam logic [gcsq_pkg::CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [gcsq_pkg::CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [gcsq_pkg::CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [gcsq_pkg::CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam int                          REPORT_MAX = 10;

    typedef struct packed {
        logic [gcsq_pkg::SIZE_W-1:0] size;
        logic [gcsq_pkg::COL_W-1:0]  col;
        logic [gcsq_pkg::ROW_W-1:0]  row;
        logic                        last;
        logic                        overrun;
    } t_cell_result;

    // Mirror of the block's state and registers
    logic [gcsq_pkg::SIZE_W-1:0] upper_row [0:gcsq_pkg::MAX_WIDTH_DEF-1];
    logic [gcsq_pkg::SIZE_W-1:0] left_size;
    logic [gcsq_pkg::SIZE_W-1:0] diag_size;
    logic [gcsq_pkg::COL_W-1:0]  cur_col;
    logic [gcsq_pkg::ROW_W-1:0]  cur_row;
    logic                        grid_done;
    logic [gcsq_pkg::GW_W-1:0]   grid_width;
    logic [gcsq_pkg::ROW_W-1:0]  grid_height;

    t_cell_result      cell_results_q [$];
    t_cell_result      want;
    t_cell_result      seen;
    int                cell_count;
    int                fail_count;

    // Work out the clearance of one non-blank character and queue the result
    task automatic predict_cell(input logic [gcsq_pkg::CHAR_W-1:0] ch);
        int           width_eff;
        int           height_eff;
        int           up;
        int           lft;
        int           dg;
        int           val;
        t_cell_result res;
        res = '0;
        width_eff = (grid_width == 0) ? 1 :
                    ((int'(grid_width) > gcsq_pkg::MAX_WIDTH_DEF) ?
                     gcsq_pkg::MAX_WIDTH_DEF : int'(grid_width));
        height_eff = (grid_height == 0) ? 1 : int'(grid_height);
        // Once full, every further cell is an overrun
        if (grid_done || int'(cur_row) >= height_eff) begin
            grid_done = 1'b1;
            res.overrun = 1'b1;
            cell_results_q.push_back(res);
            return;
        end
        up  = (cur_row != 0) ? int'(upper_row[cur_col]) : 0;
        lft = (cur_col != 0) ? int'(left_size) : 0;
        dg  = (cur_col != 0) ? int'(diag_size) : 0;
        if (ch == "S" || ch == "W" || ch == "T" || ch == "@" || ch == "O") begin
            val = 0;
        end else begin
            val = up;
            if (lft < val) val = lft;
            if (dg < val) val = dg;
            val = val + 1;
            if (val > int'(gcsq_pkg::SIZE_SAT)) val = int'(gcsq_pkg::SIZE_SAT);
        end
        upper_row[cur_col] = val[gcsq_pkg::SIZE_W-1:0];
        left_size = val[gcsq_pkg::SIZE_W-1:0];
        diag_size = up[gcsq_pkg::SIZE_W-1:0];
        res.size = val[gcsq_pkg::SIZE_W-1:0];
        res.col  = cur_col;
        res.row  = cur_row;
        // Wrap the row at the effective width, close the grid past the last row
        if (int'(cur_col) + 1 >= width_eff) begin
            cur_col = '0;
            cur_row = cur_row + 1'b1;
            if (int'(cur_row) >= height_eff || cur_row == 0) begin
                grid_done = 1'b1;
                res.last = 1'b1;
            end
        end else begin
            cur_col = cur_col + 1'b1;
        end
        cell_results_q.push_back(res);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < gcsq_pkg::MAX_WIDTH_DEF; i++) upper_row[i] = '0;
            left_size   = '0;
            diag_size   = '0;
            cur_col     = '0;
            cur_row     = '0;
            grid_done   = 1'b0;
            grid_width  = gcsq_pkg::GRID_WIDTH_RST;
            grid_height = gcsq_pkg::GRID_HEIGHT_RST;
            cell_results_q.delete();
            cell_count  = 0;
            fail_count  = 0;
        end else begin
            // Apply register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    gcsq_pkg::CFG_IDX_GRID_WIDTH:
                        grid_width  = i_cfg_data[gcsq_pkg::GW_W-1:0];
                    gcsq_pkg::CFG_IDX_GRID_HEIGHT:
                        grid_height = i_cfg_data[gcsq_pkg::ROW_W-1:0];
                    default: ;
                endcase
            end
            // Predict accepted characters; blanks give nothing
            if (map_ch.valid && map_ch.ready) begin
                if (!(map_ch.map_char == CH_SPACE || map_ch.map_char == CH_TAB ||
                      map_ch.map_char == CH_LF || map_ch.map_char == CH_CR)) begin
                    predict_cell(map_ch.map_char);
                    cell_count++;
                end
            end
            // Compare each accepted result with the oldest prediction
            if (cell_ch.valid && cell_ch.ready) begin
                seen.size    = cell_ch.square_size;
                seen.col     = cell_ch.cell_col;
                seen.row     = cell_ch.cell_row;
                seen.last    = cell_ch.last_cell;
                seen.overrun = cell_ch.too_many_chars;
                if (cell_results_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("extra result: size %0d col %0d row %0d last %0b over %0b",
                                 seen.size, seen.col, seen.row, seen.last, seen.overrun);
                end else begin
                    want = cell_results_q.pop_front();
                    if (seen !== want) begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX) begin
                            $display("cell mismatch exp: size %0d col %0d row %0d last %0b over %0b",
                                     want.size, want.col, want.row, want.last, want.overrun);
                            $display("              got: size %0d col %0d row %0d last %0b over %0b",
                                     seen.size, seen.col, seen.row, seen.last, seen.overrun);
                        end
                    end
                end
            end
        end
        o_pending <= cell_results_q.size();
        o_cells   <= cell_count;
        o_errors  <= fail_count;
    end

endmodule

### verif/tb_grid_clearance_square_dp_unit.sv
// Testbench top for the grid clearance square block: stimulus, idling and verdict.
module tb_grid_clearance_square_dp_unit;

    localparam int IDLE_LIMIT  = 5000;
    localparam int HOLD_AFTER  = 200;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 8;

    localparam logic [gcsq_pkg::CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [gcsq_pkg::CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [gcsq_pkg::CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [gcsq_pkg::CHAR_W-1:0] CH_SPACE = 8'h20;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} t_rx_mode;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [gcsq_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [gcsq_pkg::CFG_DATA_W-1:0] cfg_data;
    logic [gcsq_pkg::CHAR_W-1:0]     directed_chars [0:19];

    int pending;
    int cells;
    int errors;
    int results_seen;
    int idle_cycles;
    int burst_left;

    gcsq_in_if  map_in();
    gcsq_out_if cell_out();

    grid_clearance_square_dp_unit i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (map_in),
        .o_out      (cell_out)
    );

    gcsq_clearance_checker u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .map_ch     (map_in),
        .cell_ch    (cell_out),
        .o_pending  (pending),
        .o_cells    (cells),
        .o_errors   (errors)
    );

    // Clock
    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Count delivered results and watch for a stuck run
    always @(posedge clk) begin
        if (cell_out.valid && cell_out.ready) results_seen <= results_seen + 1;
        if ((map_in.valid && map_in.ready) || (cell_out.valid && cell_out.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: stall in random modes, and hold off once for a long stretch
    initial begin
        t_rx_mode mode;
        int       mode_left;
        bit       held;
        mode = RX_OPEN;
        mode_left = 0;
        held = 1'b0;
        cell_out.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (!held && results_seen >= HOLD_AFTER) begin
                held = 1'b1;
                cell_out.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (mode_left == 0) begin
                mode = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (mode)
                RX_OPEN:   cell_out.ready <= 1'b1;
                RX_COIN:   cell_out.ready <= ($urandom_range(0, 1) == 1);
                RX_SPARSE: cell_out.ready <= ($urandom_range(0, 3) == 0);
                default:   cell_out.ready <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    // Mostly traversable cells, some obstacles, blanks and arbitrary bytes
    function automatic logic [gcsq_pkg::CHAR_W-1:0] pick_char();
        int                          roll;
        logic [gcsq_pkg::CHAR_W-1:0] c;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            case ($urandom_range(0, 3))
                0:       c = CH_SPACE;
                1:       c = CH_TAB;
                2:       c = CH_LF;
                default: c = CH_CR;
            endcase
        end else if (roll < 16) begin
            case ($urandom_range(0, 4))
                0:       c = "S";
                1:       c = "W";
                2:       c = "T";
                3:       c = "@";
                default: c = "O";
            endcase
        end else if (roll < 20) begin
            c = gcsq_pkg::CHAR_W'($urandom_range(0, 255));
        end else begin
            do c = gcsq_pkg::CHAR_W'($urandom_range(8'h21, 8'hFE));
            while (c == "S" || c == "W" || c == "T" || c == "@" || c == "O");
        end
        return c;
    endfunction

    // Offer one item in bursts with random gaps; return after acceptance
    task automatic send_char(input logic [gcsq_pkg::CHAR_W-1:0] c);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                map_in.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        map_in.valid    <= 1'b1;
        map_in.map_char <= c;
        do @(posedge clk); while (!map_in.ready);
        @(negedge clk);
    endtask

    // Send random items until the given number of cells has gone in
    task automatic fill_to(input int total);
        while (cells < total) send_char(pick_char());
    endtask

    // Drop valid and wait until every predicted result has come out
    task automatic settle();
        map_in.valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [gcsq_pkg::CFG_IDX_W-1:0] idx, input int value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value[gcsq_pkg::CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we   <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_phase(input int width, input int height, input int total);
        settle();
        write_reg(gcsq_pkg::CFG_IDX_GRID_WIDTH, width);
        write_reg(gcsq_pkg::CFG_IDX_GRID_HEIGHT, height);
        fill_to(total);
    endtask

    initial begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = gcsq_pkg::CFG_IDX_GRID_WIDTH;
        cfg_data        = '0;
        map_in.valid    = 1'b0;
        map_in.map_char = '0;
        burst_left      = 0;
        directed_chars  = '{8'h00, 8'hFF, "S", "W", "T", "@", "O", CH_SPACE, CH_TAB, CH_LF,
                            CH_CR, ".", ".", "s", "o", 8'h7F, 8'h80, 8'h55, 8'hAA, "G"};
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // First row at full width (oversized value clamps), so the line buffer is filled
        write_reg(gcsq_pkg::CFG_IDX_GRID_WIDTH, 2047);
        write_reg(gcsq_pkg::CFG_IDX_GRID_HEIGHT, 65535);
        foreach (directed_chars[i]) send_char(directed_chars[i]);
        fill_to(1024);

        // Single-column rows from a zero width, then changing widths mid-row
        run_phase(0, 65535, 1064);
        run_phase(20, 65535, 1214);
        run_phase(5, 65535, 1315);
        run_phase(1024, 65535, 1375);
        run_phase(12, 65535, 1496);

        // Close the grid on the last row, then overrun it
        run_phase(8, 85, 1560);

        // Grid stays full whatever the registers say
        run_phase(1, 0, 1575);
        run_phase(1024, 1, 1590);

        settle();
        if (errors == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/gcsq_pkg.sv
rtl/core/gcsq_in_if.sv
rtl/core/gcsq_out_if.sv
rtl/core/gcsq_fifo.sv
rtl/core/gcsq_front.sv
rtl/core/gcsq_back.sv
rtl/core/grid_clearance_square_dp_unit.sv
verif/gcsq_clearance_checker.sv
verif/tb_grid_clearance_square_dp_unit.sv
